// ----- src/vppe_pkg.sv -----
// Shared types, codes and constants of the pixel plot engine.
package vppe_pkg;

  // Default depth of the frame store in 32-bit words
  localparam int unsigned FRAME_WORDS_DEF = 65536;

  // Field widths
  localparam int unsigned COORD_W = 10;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LANES   = WORD_W / 8;

  // Screen geometry
  localparam logic [COORD_W-1:0] CHUNKY_W = 10'd320;
  localparam logic [COORD_W-1:0] CHUNKY_H = 10'd200;
  localparam logic [COORD_W-1:0] PLANAR_W = 10'd640;
  localparam logic [COORD_W-1:0] PLANAR_H = 10'd480;

  // Last word touched by a fill in each mode
  localparam logic [ADDR_W-1:0] CHUNKY_LAST = 16'd63999;
  localparam logic [ADDR_W-1:0] PLANAR_LAST = 16'd38399;

  localparam logic [7:0] FILL_COLOR = 8'h0F;
  localparam logic [7:0] BIT_MSB    = 8'h80;

  // Graphics mode register codes
  localparam logic [1:0] MODE_TEXT   = 2'd0;
  localparam logic [1:0] MODE_CHUNKY = 2'd1;
  localparam logic [1:0] MODE_PLANAR = 2'd2;

  // Request types
  localparam logic REQ_PLOT = 1'b0;
  localparam logic REQ_FILL = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STS_WRITTEN  = 2'd0,
    STS_CLIPPED  = 2'd1,
    STS_REJECTED = 2'd2,
    STS_FILLED   = 2'd3
  } status_t;

  // Frame store write source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_FILL,
    WR_PLOT
  } wr_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load_req;
    wr_sel_t wr_sel;
    logic    cnt_inc;
    logic    cnt_clr;
    logic    out_load;
    status_t out_status;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_text;
    logic is_fill;
    logic clipped;
    logic planar;
    logic fill_last;
    logic clear_last;
  } stat_t;

endpackage

// ----- src/vga_pixel_plot_engine.sv -----
// Top level: pixel plot and fill engine over a word-organized frame store.
// After reset a clearing pass zeroes the frame store, one word a cycle, over all
// FRAME_WORDS words; in_ready stays low meanwhile, configuration is taken at once.
// Reject, clip and chunky plot results are loaded from the execute state; a planar
// plot reads its word there and writes it back in the modify state (read-modify-write
// through the registered RAM port); a fill writes 38400 (planar) or 64000 (chunky)
// frame words, one a cycle. One transaction is worked at a time.
module vga_pixel_plot_engine #(
  parameter int unsigned FRAME_WORDS = vppe_pkg::FRAME_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_gfx_mode,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req_type,
  input  logic [vppe_pkg::COORD_W-1:0] in_pixel_x,
  input  logic [vppe_pkg::COORD_W-1:0] in_pixel_y,
  input  logic [vppe_pkg::COLOR_W-1:0] in_color,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [vppe_pkg::ADDR_W-1:0]  out_byte_addr,
  output logic [7:0]                   out_plane0_byte,
  output logic [7:0]                   out_plane1_byte,
  output logic [7:0]                   out_plane2_byte,
  output logic [7:0]                   out_plane3_byte
);

  vppe_pkg::cmd_t  cmd;
  vppe_pkg::stat_t stat;

  // Configuration writes land whenever offered
  assign cfg_ready = 1'b1;

  vppe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  vppe_datapath #(
    .FRAME_WORDS (FRAME_WORDS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_gfx_mode    (cfg_gfx_mode),
    .in_req_type     (in_req_type),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_color        (in_color),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_status),
    .out_byte_addr   (out_byte_addr),
    .out_plane0_byte (out_plane0_byte),
    .out_plane1_byte (out_plane1_byte),
    .out_plane2_byte (out_plane2_byte),
    .out_plane3_byte (out_plane3_byte)
  );

endmodule

// ----- src/vppe_ram.sv -----
// Generic single-clock RAM with lane write enables and registered read.
module vppe_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W/8-1:0]      wr_be,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  localparam int unsigned NLANE = DATA_W / 8;

  logic [DATA_W-1:0] mem [DEPTH];

  // Write enabled lanes, read one word a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < NLANE; i++) begin
        if (wr_be[i]) begin
          mem[wr_addr][i*8 +: 8] <= wr_data[i*8 +: 8];
        end
      end
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/vppe_datapath.sv -----
// Datapath: request and mode registers, address and mask logic, frame store, result registers.
module vppe_datapath #(
  parameter int unsigned FRAME_WORDS = vppe_pkg::FRAME_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_gfx_mode,
  input  logic                          in_req_type,
  input  logic [vppe_pkg::COORD_W-1:0]  in_pixel_x,
  input  logic [vppe_pkg::COORD_W-1:0]  in_pixel_y,
  input  logic [vppe_pkg::COLOR_W-1:0]  in_color,
  input  vppe_pkg::cmd_t                cmd,
  output vppe_pkg::stat_t               stat,
  output logic [1:0]                    out_status,
  output logic [vppe_pkg::ADDR_W-1:0]   out_byte_addr,
  output logic [7:0]                    out_plane0_byte,
  output logic [7:0]                    out_plane1_byte,
  output logic [7:0]                    out_plane2_byte,
  output logic [7:0]                    out_plane3_byte
);

  localparam int unsigned MEM_AW = $clog2(FRAME_WORDS);
  localparam int unsigned NLANE  = vppe_pkg::LANES;
  localparam int unsigned WIDE_W = vppe_pkg::ADDR_W + 2;

  logic [1:0]                   mode_r;
  logic                         req_r;
  logic [vppe_pkg::COORD_W-1:0] x_r;
  logic [vppe_pkg::COORD_W-1:0] y_r;
  logic [vppe_pkg::COLOR_W-1:0] color_r;
  logic [MEM_AW-1:0]            cnt_r;

  logic                         chunky;
  logic                         planar;
  logic [WIDE_W-1:0]            chunky_sum;
  logic [WIDE_W-1:0]            planar_sum;
  logic [vppe_pkg::ADDR_W-1:0]  plot_addr;
  logic [7:0]                   bit_mask;
  logic [vppe_pkg::WORD_W-1:0]  rd_word;
  logic [vppe_pkg::WORD_W-1:0]  new_word;
  logic [vppe_pkg::ADDR_W-1:0]  fill_last_addr;

  logic                         mem_we;
  logic [MEM_AW-1:0]            mem_addr;
  logic [NLANE-1:0]             mem_be;
  logic [vppe_pkg::WORD_W-1:0]  mem_wdata;
  logic [vppe_pkg::WORD_W-1:0]  mem_rdata;

  logic [1:0]                   status_r;
  logic [vppe_pkg::ADDR_W-1:0]  addr_r;
  logic [vppe_pkg::WORD_W-1:0]  word_r;

  // Hold mode register and request fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= vppe_pkg::MODE_TEXT;
    end else if (cfg_we) begin
      mode_r <= cfg_gfx_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r   <= in_req_type;
      x_r     <= in_pixel_x;
      y_r     <= in_pixel_y;
      color_r <= in_color;
    end
  end

  // Decode mode and clip the pixel
  assign chunky = (mode_r == vppe_pkg::MODE_CHUNKY);
  assign planar = (mode_r == vppe_pkg::MODE_PLANAR);

  assign stat.is_text = !chunky && !planar;
  assign stat.is_fill = (req_r == vppe_pkg::REQ_FILL);
  assign stat.planar  = planar;
  assign stat.clipped = chunky ? (x_r >= vppe_pkg::CHUNKY_W || y_r >= vppe_pkg::CHUNKY_H)
                               : (x_r >= vppe_pkg::PLANAR_W || y_r >= vppe_pkg::PLANAR_H);

  // Word offset: 320*y+x or 80*y+x/8 by shifts and adds
  assign chunky_sum = {y_r, 8'b0} + WIDE_W'({y_r, 6'b0}) + WIDE_W'(x_r);
  assign planar_sum = WIDE_W'({y_r, 6'b0}) + WIDE_W'({y_r, 4'b0}) + WIDE_W'(x_r[9:3]);
  assign plot_addr  = chunky ? chunky_sum[vppe_pkg::ADDR_W-1:0]
                             : planar_sum[vppe_pkg::ADDR_W-1:0];

  // Set or clear the pixel bit in each plane lane
  assign bit_mask = vppe_pkg::BIT_MSB >> x_r[2:0];
  assign rd_word  = mem_rdata;

  always_comb begin
    for (int p = 0; p < NLANE; p++) begin
      new_word[p*8 +: 8] = color_r[p] ? (rd_word[p*8 +: 8] | bit_mask)
                                      : (rd_word[p*8 +: 8] & ~bit_mask);
    end
  end

  // Sweep counter for clearing and filling
  assign fill_last_addr  = chunky ? vppe_pkg::CHUNKY_LAST : vppe_pkg::PLANAR_LAST;
  assign stat.fill_last  = (vppe_pkg::ADDR_W'(cnt_r) == fill_last_addr);
  assign stat.clear_last = (cnt_r == MEM_AW'(FRAME_WORDS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + MEM_AW'(1);
    end
  end

  // Select frame store write source
  always_comb begin
    mem_we    = 1'b1;
    mem_addr  = MEM_AW'(plot_addr);
    mem_be    = '1;
    mem_wdata = '0;
    unique case (cmd.wr_sel)
      vppe_pkg::WR_NONE: begin
        mem_we = 1'b0;
      end
      vppe_pkg::WR_CLEAR: begin
        mem_addr = cnt_r;
      end
      vppe_pkg::WR_FILL: begin
        mem_addr = cnt_r;
        if (planar) begin
          mem_wdata = '1;
        end else begin
          mem_be    = NLANE'(1);
          mem_wdata = vppe_pkg::WORD_W'(vppe_pkg::FILL_COLOR);
        end
      end
      vppe_pkg::WR_PLOT: begin
        if (planar) begin
          mem_wdata = new_word;
        end else begin
          mem_be    = NLANE'(1);
          mem_wdata = vppe_pkg::WORD_W'(color_r);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  vppe_ram #(
    .DATA_W (vppe_pkg::WORD_W),
    .DEPTH  (FRAME_WORDS)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_addr),
    .wr_be   (mem_be),
    .wr_data (mem_wdata),
    .rd_addr (mem_addr),
    .rd_data (mem_rdata)
  );

  // Capture the result transaction
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r <= cmd.out_status;
      if (cmd.out_status == vppe_pkg::STS_WRITTEN) begin
        addr_r <= plot_addr;
        word_r <= planar ? new_word : vppe_pkg::WORD_W'(color_r);
      end else begin
        addr_r <= '0;
        word_r <= '0;
      end
    end
  end

  assign out_status      = status_r;
  assign out_byte_addr   = addr_r;
  assign out_plane0_byte = word_r[7:0];
  assign out_plane1_byte = word_r[15:8];
  assign out_plane2_byte = word_r[23:16];
  assign out_plane3_byte = word_r[31:24];

endmodule

// ----- src/vppe_ctrl.sv -----
// Controller: sequences clearing, plots and fills, and owns both handshakes.
module vppe_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  vppe_pkg::stat_t stat,
  output vppe_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MODIFY,
    S_FILL,
    S_FILL_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Decode commands and next state
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.wr_sel     = vppe_pkg::WR_NONE;
    cmd.out_status = vppe_pkg::STS_WRITTEN;
    unique case (state_r)
      S_CLEAR: begin
        cmd.wr_sel = vppe_pkg::WR_CLEAR;
        if (stat.clear_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (stat.is_text) begin
          if (slot_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = vppe_pkg::STS_REJECTED;
            state_nxt      = S_IDLE;
          end
        end else if (stat.is_fill) begin
          state_nxt = S_FILL;
        end else if (stat.clipped) begin
          if (slot_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = vppe_pkg::STS_CLIPPED;
            state_nxt      = S_IDLE;
          end
        end else if (stat.planar) begin
          state_nxt = S_MODIFY;
        end else begin
          if (slot_free) begin
            cmd.wr_sel   = vppe_pkg::WR_PLOT;
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_MODIFY: begin
        if (slot_free) begin
          cmd.wr_sel   = vppe_pkg::WR_PLOT;
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FILL: begin
        cmd.wr_sel = vppe_pkg::WR_FILL;
        if (stat.fill_last) begin
          state_nxt = S_FILL_DONE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_FILL_DONE: begin
        if (slot_free) begin
          cmd.cnt_clr    = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_status = vppe_pkg::STS_FILLED;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Set on a new result, drop when the transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/vppe_checker.sv -----
// Port-level checker for the pixel plot engine and its bind.
module vppe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_byte_addr,
  input logic [7:0]  out_plane0_byte,
  input logic [7:0]  out_plane1_byte,
  input logic [7:0]  out_plane2_byte,
  input logic [7:0]  out_plane3_byte
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_byte_addr))
    else $error("stalled result changed");

  // Only written pixels carry address and plane data
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != vppe_pkg::STS_WRITTEN |->
      out_byte_addr == 16'd0 && out_plane0_byte == 8'd0 && out_plane1_byte == 8'd0 &&
      out_plane2_byte == 8'd0 && out_plane3_byte == 8'd0)
    else $error("non-write result carries data");

  // Plane lanes above zero come only from planar plots, whose offsets stay on screen
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_plane1_byte != 8'd0 || out_plane2_byte != 8'd0 ||
                  out_plane3_byte != 8'd0) |-> out_byte_addr < 16'd38400)
    else $error("planar result beyond screen");

  // The clearing pass holds off requests right after reset
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("request taken during clearing pass");

  // One transaction in work at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

endmodule

bind vga_pixel_plot_engine vppe_checker u_vppe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_byte_addr   (out_byte_addr),
  .out_plane0_byte (out_plane0_byte),
  .out_plane1_byte (out_plane1_byte),
  .out_plane2_byte (out_plane2_byte),
  .out_plane3_byte (out_plane3_byte)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the pixel plot and fill engine.
module tb_top;
  import vppe_pkg::*;

  // Mode code with no screen behind it; the engine treats it as text mode
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 70;
  localparam int TEXT_ITEMS  = 15;

  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
  } pixel_req_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        plane0;
    logic [7:0]        plane1;
    logic [7:0]        plane2;
    logic [7:0]        plane3;
  } plot_res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_gfx_mode = MODE_TEXT;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_req_type = REQ_PLOT;
  logic [COORD_W-1:0] in_pixel_x = '0;
  logic [COORD_W-1:0] in_pixel_y = '0;
  logic [COLOR_W-1:0] in_color = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [ADDR_W-1:0]  out_byte_addr;
  logic [7:0]         out_plane0_byte;
  logic [7:0]         out_plane1_byte;
  logic [7:0]         out_plane2_byte;
  logic [7:0]         out_plane3_byte;

  // Shadow of the engine: frame store and mode register
  bit [WORD_W-1:0] frame_model [FRAME_WORDS_DEF];
  logic [1:0]      gfx_mode_q = MODE_TEXT;

  pixel_req_t request_q[$];
  plot_res_t  plot_results_due[$];
  pixel_req_t cur_req;
  plot_res_t  oldest_res;
  int         in_sent_cnt = 0;
  int         in_done_cnt = 0;
  int         fault_cnt = 0;
  int         fills_left = 4;
  int         req_gap = 0;
  int         res_stall = 0;
  bit         idle_on = 1'b1;

  vga_pixel_plot_engine DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_gfx_mode    (cfg_gfx_mode),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_color        (in_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_byte_addr   (out_byte_addr),
    .out_plane0_byte (out_plane0_byte),
    .out_plane1_byte (out_plane1_byte),
    .out_plane2_byte (out_plane2_byte),
    .out_plane3_byte (out_plane3_byte)
  );

  always #1 clk = ~clk;

  task automatic log_fault(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fault_cnt++;
  endtask

  task automatic check_field(string name, logic [15:0] got_v, logic [15:0] exp_v);
    if (got_v !== exp_v) begin
      log_fault($sformatf("%s got 0x%0h, want 0x%0h", name, got_v, exp_v));
    end
  endtask

  // Apply one request to the shadow store and return the result it yields
  function automatic plot_res_t compute_plot_result(pixel_req_t r);
    plot_res_t   res;
    logic [31:0] word;
    logic [7:0]  mask;
    int unsigned addr;
    res = '0;
    if (gfx_mode_q != MODE_CHUNKY && gfx_mode_q != MODE_PLANAR) begin
      res.status = STS_REJECTED;
    end else if (r.req_type == REQ_FILL) begin
      res.status = STS_FILLED;
      if (gfx_mode_q == MODE_CHUNKY) begin
        for (int i = 0; i <= int'(CHUNKY_LAST); i++) frame_model[i][7:0] = FILL_COLOR;
      end else begin
        // Color 0x0F sets every bit of all four planes
        for (int i = 0; i <= int'(PLANAR_LAST); i++) frame_model[i] = '1;
      end
    end else if (gfx_mode_q == MODE_CHUNKY) begin
      if (r.x >= CHUNKY_W || r.y >= CHUNKY_H) begin
        res.status = STS_CLIPPED;
      end else begin
        addr = int'(CHUNKY_W) * int'(r.y) + int'(r.x);
        frame_model[addr][7:0] = r.color;
        res.status = STS_WRITTEN;
        res.addr = addr[ADDR_W-1:0];
        res.plane0 = r.color;
      end
    end else begin
      if (r.x >= PLANAR_W || r.y >= PLANAR_H) begin
        res.status = STS_CLIPPED;
      end else begin
        addr = (int'(PLANAR_W) / 8) * int'(r.y) + int'(r.x >> 3);
        word = frame_model[addr];
        mask = BIT_MSB >> r.x[2:0];
        for (int p = 0; p < LANES; p++) begin
          if (r.color[p]) word[8*p +: 8] = word[8*p +: 8] | mask;
          else word[8*p +: 8] = word[8*p +: 8] & ~mask;
        end
        frame_model[addr] = word;
        res.status = STS_WRITTEN;
        res.addr = addr[ADDR_W-1:0];
        res.plane0 = word[7:0];
        res.plane1 = word[15:8];
        res.plane2 = word[23:16];
        res.plane3 = word[31:24];
      end
    end
    return res;
  endfunction

  // Drive the next request once the previous transaction has been taken
  always @(negedge clk) begin
    if (rst_n && in_done_cnt == in_sent_cnt) begin
      if (req_gap > 0) begin
        in_valid <= 1'b0;
        req_gap--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        req_gap = $urandom_range(0, 17);
      end else if (request_q.size() > 0) begin
        cur_req = request_q.pop_front();
        in_req_type <= cur_req.req_type;
        in_pixel_x <= cur_req.x;
        in_pixel_y <= cur_req.y;
        in_color <= cur_req.color;
        in_valid <= 1'b1;
        in_sent_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (res_stall > 0) begin
        out_ready <= 1'b0;
        res_stall--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        res_stall = $urandom_range(0, 17);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check each result against the oldest prediction, predict each accepted request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (plot_results_due.size() == 0) begin
          log_fault($sformatf("result with nothing pending, status %0d", out_status));
        end else begin
          oldest_res = plot_results_due.pop_front();
          check_field("status", 16'(out_status), 16'(oldest_res.status));
          check_field("byte_addr", out_byte_addr, oldest_res.addr);
          check_field("plane0_byte", 16'(out_plane0_byte), 16'(oldest_res.plane0));
          check_field("plane1_byte", 16'(out_plane1_byte), 16'(oldest_res.plane1));
          check_field("plane2_byte", 16'(out_plane2_byte), 16'(oldest_res.plane2));
          check_field("plane3_byte", 16'(out_plane3_byte), 16'(oldest_res.plane3));
        end
      end
      if (in_valid && in_ready) begin
        plot_results_due.push_back(compute_plot_result(
          pixel_req_t'{in_req_type, in_pixel_x, in_pixel_y, in_color}));
        in_done_cnt++;
      end
    end
  end

  task automatic push_req(logic t, int unsigned x, int unsigned y, int unsigned c);
    pixel_req_t r;
    r.req_type = t;
    r.x = x[COORD_W-1:0];
    r.y = y[COORD_W-1:0];
    r.color = c[COLOR_W-1:0];
    request_q.push_back(r);
  endtask

  // Mostly on-screen or clustered plots, some anywhere; rare fills, one in four in text modes
  task automatic queue_random(int n);
    pixel_req_t  r;
    int unsigned w;
    int unsigned h;
    w = (gfx_mode_q == MODE_PLANAR) ? 32'(PLANAR_W) : 32'(CHUNKY_W);
    h = (gfx_mode_q == MODE_PLANAR) ? 32'(PLANAR_H) : 32'(CHUNKY_H);
    repeat (n) begin
      r.req_type = REQ_PLOT;
      if (gfx_mode_q == MODE_TEXT || gfx_mode_q == MODE_UNUSED) begin
        if ($urandom_range(0, 3) == 0) r.req_type = REQ_FILL;
      end else if (fills_left > 0 && $urandom_range(0, 199) == 0) begin
        r.req_type = REQ_FILL;
        fills_left--;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          r.x = COORD_W'($urandom_range(0, 1023));
          r.y = COORD_W'($urandom_range(0, 1023));
        end
        2, 3, 4: begin
          r.x = COORD_W'($urandom_range(0, 31));
          r.y = COORD_W'($urandom_range(0, 3));
        end
        default: begin
          r.x = COORD_W'($urandom_range(0, w - 1));
          r.y = COORD_W'($urandom_range(0, h - 1));
        end
      endcase
      r.color = COLOR_W'($urandom_range(0, 255));
      request_q.push_back(r);
    end
  endtask

  // Hold until every request is taken and every result has come back
  task automatic drain();
    do @(negedge clk);
    while (request_q.size() != 0 || in_sent_cnt != in_done_cnt ||
           plot_results_due.size() != 0);
  endtask

  task automatic program_mode(logic [1:0] mode);
    @(negedge clk);
    cfg_gfx_mode <= mode;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    gfx_mode_q = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned sel;
    logic [1:0]  mode;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Text mode from reset, then the unused mode code: everything rejected
    push_req(REQ_PLOT, 10, 10, 'h55);
    push_req(REQ_FILL, 0, 0, 0);
    drain();
    program_mode(MODE_UNUSED);
    push_req(REQ_PLOT, 5, 5, 'hFF);
    push_req(REQ_FILL, 1023, 1023, 'hFF);
    drain();

    // Chunky: corners, clipping on each axis, fill and overwrite
    program_mode(MODE_CHUNKY);
    push_req(REQ_PLOT, 0, 0, 'hFF);
    push_req(REQ_PLOT, 319, 199, 'h00);
    push_req(REQ_PLOT, 320, 0, 'h12);
    push_req(REQ_PLOT, 0, 200, 'h34);
    push_req(REQ_PLOT, 1023, 1023, 'hFF);
    push_req(REQ_PLOT, 100, 50, 'hA5);
    push_req(REQ_FILL, 0, 0, 0);
    push_req(REQ_PLOT, 100, 50, 'h5A);
    drain();

    // Planar: bits sharing a word, upper color bits ignored, fill then clear a bit
    program_mode(MODE_PLANAR);
    push_req(REQ_PLOT, 0, 0, 'h0F);
    push_req(REQ_PLOT, 7, 0, 'h0A);
    push_req(REQ_PLOT, 639, 479, 'h05);
    push_req(REQ_PLOT, 640, 0, 'h01);
    push_req(REQ_PLOT, 0, 480, 'h01);
    push_req(REQ_PLOT, 3, 2, 'hF0);
    push_req(REQ_PLOT, 100, 50, 'h03);
    push_req(REQ_FILL, 0, 0, 0);
    push_req(REQ_PLOT, 8, 0, 'h00);
    push_req(REQ_PLOT, 1023, 0, 'hFF);
    drain();

    // Random phases over all mode codes
    for (int k = 0; k < RAND_PHASES; k++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: mode = MODE_TEXT;
        1: mode = MODE_UNUSED;
        2, 3, 4, 5: mode = MODE_CHUNKY;
        default: mode = MODE_PLANAR;
      endcase
      program_mode(mode);
      idle_on = ($urandom_range(0, 3) != 0);
      queue_random((sel < 2) ? TEXT_ITEMS : PHASE_ITEMS);
      drain();
    end

    // Closing phase at full rate
    idle_on = 1'b0;
    program_mode(($urandom_range(0, 1) == 0) ? MODE_CHUNKY : MODE_PLANAR);
    queue_random(60);
    drain();
    repeat (40) @(negedge clk);

    if (fault_cnt == 0) begin
      $display("[vga_pixel_plot_engine] OK");
    end else begin
      $display("[vga_pixel_plot_engine] ERROR");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #6_000_000;
    $display("[vga_pixel_plot_engine] ERROR");
    $finish;
  end

endmodule
